[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, ignored while reset is high
`define CWSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define CWSP_ASSERT_NEXT(label, pre, post, msg) \
  `CWSP_ASSERT(label, (pre) |=> (post), msg)

`endif

[src/cwsp_pkg.sv]
// shared types, codes and helpers of the congestion weighted shortest path unit
package cwsp_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ADJUST = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [15:0] CARS_MAX    = 16'hFFFF;
  localparam logic [10:0] LANE_SCALE  = 11'd100;
  localparam logic [6:0]  NODES_RESET = 7'd64;

  typedef struct packed {
    logic [5:0]  start;
    logic [5:0]  dest;
    logic [15:0] length;
    logic [3:0]  lanes;
    logic [15:0] cars;
  } edge_entry_t;

  typedef struct packed {
    logic reached;
    logic settled;
  } node_flags_t;

  typedef struct packed {
    logic        go;
    logic [15:0] length;
    logic [3:0]  lanes;
    logic [15:0] cars;
  } weight_req_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage

[src/cwsp_weight.sv]
// congested edge weight: length*256 + floor(length*256*cars/(100*lanes)), bit-serial divide
module cwsp_weight (
  input  logic                  clk,
  input  logic                  rst,
  input  cwsp_pkg::weight_req_t req,
  output logic                  done,
  output logic [31:0]           weight
);
  import cwsp_pkg::*;

  typedef enum logic [1:0] {W_IDLE, W_DIV, W_FIN} wstate_t;

  localparam int DIV_STEPS = 40;
  localparam int STEP_W    = 6;

  wstate_t           state;
  logic [STEP_W-1:0] step;
  logic [39:0]       quo;
  logic [10:0]       rem;
  logic [10:0]       den;
  logic [15:0]       length;
  logic [11:0]       trial;
  logic              fits;
  logic [40:0]       sum;
  logic [3:0]        lanes_eff;

  always_comb begin
    trial     = {rem, quo[39]};
    fits      = trial >= {1'b0, den};
    sum       = {1'b0, quo} + {17'b0, length, 8'b0};
    lanes_eff = (req.lanes == 4'd0) ? 4'd1 : req.lanes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (req.go) begin
            quo    <= {{16'b0, req.length} * {16'b0, req.cars}, 8'b0};
            den    <= {7'b0, lanes_eff} * LANE_SCALE;
            length <= req.length;
            rem    <= '0;
            step   <= '0;
            state  <= W_DIV;
          end
        end
        W_DIV: begin
          quo  <= {quo[38:0], fits};
          rem  <= fits ? 11'(trial - {1'b0, den}) : trial[10:0];
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= W_FIN;
          end
        end
        W_FIN: begin
          weight <= (sum[40:32] != '0) ? SAT32 : sum[31:0];
          done   <= 1'b1;
          state  <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

[src/cwsp_edge_mem.sv]
// edge table: synchronous memory of edge entries plus per-slot valid bits
module cwsp_edge_mem #(
  parameter int  EDGE_COUNT = 256,
  localparam int EW         = $clog2(EDGE_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [EW-1:0]         rd_addr,
  output logic                  rd_valid,
  output cwsp_pkg::edge_entry_t rd_entry,
  input  logic                  wr_en,
  input  logic [EW-1:0]         wr_addr,
  input  cwsp_pkg::edge_entry_t wr_entry
);
  import cwsp_pkg::*;

  edge_entry_t             mem [EDGE_COUNT];
  logic [EDGE_COUNT-1:0]   valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

[src/cwsp_node_mem.sv]
// node store: distance and back edge memory, reached and settled flags
module cwsp_node_mem #(
  parameter int  NODE_COUNT = 64,
  parameter int  EDGE_COUNT = 256,
  localparam int NW         = $clog2(NODE_COUNT),
  localparam int EW         = $clog2(EDGE_COUNT)
) (
  input  logic                  clk,
  input  logic                  clear,
  input  logic                  rd_en,
  input  logic [NW-1:0]         rd_addr,
  output logic [31:0]           rd_dist,
  output logic [EW-1:0]         rd_back,
  output cwsp_pkg::node_flags_t rd_flags,
  input  logic                  wr_en,
  input  logic [NW-1:0]         wr_addr,
  input  logic [31:0]           wr_dist,
  input  logic [EW-1:0]         wr_back,
  input  logic                  settle_en,
  input  logic [NW-1:0]         settle_addr
);
  import cwsp_pkg::*;

  logic [31:0]           dist_mem [NODE_COUNT];
  logic [EW-1:0]         back_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] reached;
  logic [NODE_COUNT-1:0] settled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      back_mem[wr_addr] <= wr_back;
    end
    if (rd_en) begin
      rd_dist  <= dist_mem[rd_addr];
      rd_back  <= back_mem[rd_addr];
      rd_flags <= {reached[rd_addr], settled[rd_addr]};
    end
  end

  // clear at query start; a write in the same cycle still marks its node
  always_ff @(posedge clk) begin
    if (clear) begin
      reached <= '0;
      settled <= '0;
    end
    if (wr_en) begin
      reached[wr_addr] <= 1'b1;
    end
    if (settle_en) begin
      settled[settle_addr] <= 1'b1;
    end
  end

endmodule

[src/congestion_weighted_shortest_path_unit.sv]
// top level: command decode, search sequencer and result register of the route unit
//
// a directed edge table (EDGE_COUNT slots) and a node store (NODE_COUNT entries) sit in
// synchronous memories; one sequencer walks them. a load writes its slot from idle, an
// adjust reads the slot, modifies it and writes it back. a query first clears the node
// flags, then repeats: a minimum scan over the nodes in use (one memory read each) and
// a relaxation pass over every edge slot; each valid slot leaving the settled node for
// a node in use waits on the bit-serial divider of the weight unit. the route is then
// read back from the destination one path edge per beat, each beat held while the
// receiver stalls. commands are stalled for the whole query. the valid bits of the
// edge table clear at reset, so no clearing pass is needed.
module congestion_weighted_shortest_path_unit #(
  parameter int NODE_COUNT = 64,
  parameter int EDGE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  edge_slot,
  input  logic [5:0]  from_node,
  input  logic [5:0]  to_node,
  input  logic [15:0] road_length,
  input  logic [3:0]  lane_count,
  input  logic        count_up,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  path_edge,
  output logic        edge_present,
  output logic        reachable,
  output logic [31:0] total_cost,
  output logic        last,
  // configuration
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import cwsp_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = $clog2(EDGE_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADJUST, ST_SCAN_RD, ST_SCAN_CMP, ST_PICK,
    ST_EDGE_RD, ST_EDGE_CHK, ST_EDGE_WAIT,
    ST_WALK_NODE, ST_WALK_EDGE, ST_WALK_START, ST_WALK_WAIT, ST_OUT
  } state_t;

  state_t        state;
  logic [6:0]    nodes_in_use;
  logic [NW-1:0] src;
  logic [NW-1:0] dst;
  logic [EW-1:0] adj_slot;
  logic          adj_up;
  logic [NW:0]   node_idx;
  logic          best_found;
  logic [NW-1:0] best_node;
  logic [31:0]   best_dist;
  logic [NW-1:0] cur;
  logic [31:0]   cur_dist;
  logic [EW:0]   slot_idx;
  logic [NW-1:0] walk;
  logic [NW:0]   steps;
  logic [31:0]   total;

  // memory and weight unit hookup
  logic          e_rd_en, e_rd_valid, e_wr_en;
  logic [EW-1:0] e_rd_addr, e_wr_addr;
  edge_entry_t   e_rd_entry, e_wr_entry;
  logic          n_clear, n_rd_en, n_wr_en, n_settle_en;
  logic [NW-1:0] n_rd_addr, n_wr_addr, n_settle_addr;
  logic [31:0]   n_rd_dist, n_wr_dist;
  logic [EW-1:0] n_rd_back, n_wr_back;
  node_flags_t   n_rd_flags;
  weight_req_t   w_req;
  logic          w_done;
  logic [31:0]   w_weight;

  // index widening and narrowing between port fields and internal widths
  logic [NW:0]    limit;
  logic [NW+7:0]  nodes_wide;
  logic [EW+7:0]  slot_wide;
  logic           slot_ok;
  logic [NW+5:0]  from_wide, to_wide, start_wide, dest_wide;
  logic           from_ok, to_ok, dest_ok, start_hit;
  logic [EW+7:0]  back_wide;
  logic [15:0]    cars_adj, cars_less;
  logic [31:0]    relax_cost, walk_total;
  logic           walk_fin;
  logic           accept;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && (state == ST_IDLE);

  always_comb begin
    nodes_wide = {{(NW+1){1'b0}}, nodes_in_use};
    limit      = (nodes_wide > (NW+8)'(NODE_COUNT)) ? (NW+1)'(NODE_COUNT) : nodes_wide[NW:0];
    slot_wide  = {{EW{1'b0}}, edge_slot};
    slot_ok    = slot_wide < (EW+8)'(EDGE_COUNT);
    from_wide  = {{NW{1'b0}}, from_node};
    to_wide    = {{NW{1'b0}}, to_node};
    from_ok    = {{(NW+1){1'b0}}, from_node} < {6'b0, limit};
    to_ok      = {{(NW+1){1'b0}}, to_node} < {6'b0, limit};
    start_wide = {{NW{1'b0}}, e_rd_entry.start};
    dest_wide  = {{NW{1'b0}}, e_rd_entry.dest};
    start_hit  = start_wide == {6'b0, cur};
    dest_ok    = {{(NW+1){1'b0}}, e_rd_entry.dest} < {6'b0, limit};
    back_wide  = {8'b0, n_rd_back};
    // adjust: raise saturates, lower stops at zero
    if (adj_up) begin
      cars_adj = (e_rd_entry.cars == CARS_MAX) ? e_rd_entry.cars : e_rd_entry.cars + 1'b1;
    end else begin
      cars_adj = (e_rd_entry.cars == '0) ? e_rd_entry.cars : e_rd_entry.cars - 1'b1;
    end
    cars_less  = (e_rd_entry.cars == '0) ? '0 : e_rd_entry.cars - 1'b1;
    relax_cost = sat_add(cur_dist, w_weight);
    walk_total = sat_add(total, w_weight);
    walk_fin   = (start_wide[NW-1:0] == src) || (steps == (NW+1)'(NODE_COUNT - 1));
  end

  // memory strobes follow the sequencer state
  always_comb begin
    e_rd_en       = 1'b0;
    e_rd_addr     = slot_idx[EW-1:0];
    e_wr_en       = 1'b0;
    e_wr_addr     = adj_slot;
    e_wr_entry    = e_rd_entry;
    n_clear       = 1'b0;
    n_rd_en       = 1'b0;
    n_rd_addr     = node_idx[NW-1:0];
    n_wr_en       = 1'b0;
    n_wr_addr     = dest_wide[NW-1:0];
    n_wr_dist     = relax_cost;
    n_wr_back     = slot_idx[EW-1:0];
    n_settle_en   = 1'b0;
    n_settle_addr = best_node;
    w_req         = '{go: 1'b0, length: e_rd_entry.length, lanes: e_rd_entry.lanes,
                      cars: e_rd_entry.cars};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_LOAD && slot_ok) begin
            e_wr_en    = 1'b1;
            e_wr_addr  = slot_wide[EW-1:0];
            e_wr_entry = '{start: from_node, dest: to_node, length: road_length,
                           lanes: lane_count, cars: 16'd0};
          end else if (command == CMD_ADJUST && slot_ok) begin
            e_rd_en   = 1'b1;
            e_rd_addr = slot_wide[EW-1:0];
          end else if (command == CMD_QUERY) begin
            n_clear = 1'b1;
            if (from_ok && to_ok) begin
              // source enters reached at distance zero
              n_wr_en   = 1'b1;
              n_wr_addr = from_wide[NW-1:0];
              n_wr_dist = '0;
              n_wr_back = '0;
            end
          end
        end
      end
      ST_ADJUST: begin
        if (e_rd_valid) begin
          e_wr_en         = 1'b1;
          e_wr_entry.cars = cars_adj;
        end
      end
      ST_SCAN_RD: begin
        n_rd_en = (node_idx != limit);
      end
      ST_PICK: begin
        n_settle_en = best_found;
      end
      ST_EDGE_RD: begin
        e_rd_en = (slot_idx != (EW+1)'(EDGE_COUNT));
      end
      ST_EDGE_CHK: begin
        if (e_rd_valid && start_hit && dest_ok) begin
          w_req.go  = 1'b1;
          n_rd_en   = 1'b1;
          n_rd_addr = dest_wide[NW-1:0];
        end
      end
      ST_EDGE_WAIT: begin
        // strict improvement only
        n_wr_en = w_done && (!n_rd_flags.reached || n_rd_dist > relax_cost);
      end
      ST_WALK_NODE: begin
        n_rd_en   = 1'b1;
        n_rd_addr = walk;
      end
      ST_WALK_EDGE: begin
        e_rd_en   = 1'b1;
        e_rd_addr = n_rd_back;
      end
      ST_WALK_START: begin
        w_req.go   = 1'b1;
        w_req.cars = cars_less;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      res_valid    <= 1'b0;
      nodes_in_use <= NODES_RESET;
    end else begin
      if (cfg_we) begin
        nodes_in_use <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            src      <= from_wide[NW-1:0];
            dst      <= to_wide[NW-1:0];
            adj_slot <= slot_wide[EW-1:0];
            adj_up   <= count_up;
            if (command == CMD_ADJUST && slot_ok) begin
              state <= ST_ADJUST;
            end else if (command == CMD_QUERY) begin
              if (from_ok && to_ok) begin
                node_idx   <= '0;
                best_found <= 1'b0;
                state      <= ST_SCAN_RD;
              end else begin
                // endpoint outside the nodes in use: unreachable
                path_edge    <= '0;
                edge_present <= 1'b0;
                reachable    <= 1'b0;
                total_cost   <= '0;
                last         <= 1'b1;
                res_valid    <= 1'b1;
                state        <= ST_OUT;
              end
            end
          end
        end
        ST_ADJUST: state <= ST_IDLE;
        ST_SCAN_RD: begin
          state <= (node_idx == limit) ? ST_PICK : ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          // ties keep the lower node since only a smaller distance replaces
          if (n_rd_flags.reached && !n_rd_flags.settled &&
              (!best_found || n_rd_dist < best_dist)) begin
            best_found <= 1'b1;
            best_node  <= node_idx[NW-1:0];
            best_dist  <= n_rd_dist;
          end
          node_idx <= node_idx + 1'b1;
          state    <= ST_SCAN_RD;
        end
        ST_PICK: begin
          if (!best_found) begin
            path_edge    <= '0;
            edge_present <= 1'b0;
            reachable    <= 1'b0;
            total_cost   <= '0;
            last         <= 1'b1;
            res_valid    <= 1'b1;
            state        <= ST_OUT;
          end else if (best_node == dst) begin
            if (dst == src) begin
              path_edge    <= '0;
              edge_present <= 1'b0;
              reachable    <= 1'b1;
              total_cost   <= '0;
              last         <= 1'b1;
              res_valid    <= 1'b1;
              state        <= ST_OUT;
            end else begin
              walk  <= dst;
              steps <= '0;
              total <= '0;
              state <= ST_WALK_NODE;
            end
          end else begin
            cur      <= best_node;
            cur_dist <= best_dist;
            slot_idx <= '0;
            state    <= ST_EDGE_RD;
          end
        end
        ST_EDGE_RD: begin
          if (slot_idx == (EW+1)'(EDGE_COUNT)) begin
            node_idx   <= '0;
            best_found <= 1'b0;
            state      <= ST_SCAN_RD;
          end else begin
            state <= ST_EDGE_CHK;
          end
        end
        ST_EDGE_CHK: begin
          if (e_rd_valid && start_hit && dest_ok) begin
            state <= ST_EDGE_WAIT;
          end else begin
            slot_idx <= slot_idx + 1'b1;
            state    <= ST_EDGE_RD;
          end
        end
        ST_EDGE_WAIT: begin
          if (w_done) begin
            slot_idx <= slot_idx + 1'b1;
            state    <= ST_EDGE_RD;
          end
        end
        ST_WALK_NODE:  state <= ST_WALK_EDGE;
        ST_WALK_EDGE:  state <= ST_WALK_START;
        ST_WALK_START: state <= ST_WALK_WAIT;
        ST_WALK_WAIT: begin
          if (w_done) begin
            // path cost uses one car fewer than the search did
            path_edge    <= back_wide[7:0];
            edge_present <= 1'b1;
            reachable    <= walk_fin;
            total_cost   <= walk_fin ? walk_total : '0;
            last         <= walk_fin;
            res_valid    <= 1'b1;
            total        <= walk_total;
            walk         <= start_wide[NW-1:0];
            steps        <= steps + 1'b1;
            state        <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            state     <= last ? ST_IDLE : ST_WALK_NODE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  cwsp_edge_mem #(.EDGE_COUNT(EDGE_COUNT)) u_edge_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (e_rd_en),
    .rd_addr  (e_rd_addr),
    .rd_valid (e_rd_valid),
    .rd_entry (e_rd_entry),
    .wr_en    (e_wr_en),
    .wr_addr  (e_wr_addr),
    .wr_entry (e_wr_entry)
  );

  cwsp_node_mem #(.NODE_COUNT(NODE_COUNT), .EDGE_COUNT(EDGE_COUNT)) u_node_mem (
    .clk         (clk),
    .clear       (n_clear),
    .rd_en       (n_rd_en),
    .rd_addr     (n_rd_addr),
    .rd_dist     (n_rd_dist),
    .rd_back     (n_rd_back),
    .rd_flags    (n_rd_flags),
    .wr_en       (n_wr_en),
    .wr_addr     (n_wr_addr),
    .wr_dist     (n_wr_dist),
    .wr_back     (n_wr_back),
    .settle_en   (n_settle_en),
    .settle_addr (n_settle_addr)
  );

  cwsp_weight u_weight (
    .clk    (clk),
    .rst    (rst),
    .req    (w_req),
    .done   (w_done),
    .weight (w_weight)
  );

endmodule

[src/cwsp_checker.sv]
// port-level checks of the route unit and their bind
`include "assert_macros.svh"

module cwsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [7:0]  path_edge,
  input logic        edge_present,
  input logic        reachable,
  input logic [31:0] total_cost,
  input logic        last
);

  `CWSP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(path_edge) && $stable(last) && $stable(total_cost), "stalled result beat changed")
  `CWSP_ASSERT(a_no_cmd_during_res, res_valid |-> cmd_stall, "command taken while a result waits")
  `CWSP_ASSERT(a_mid_beat, res_valid && !last |-> edge_present && !reachable && total_cost == 32'd0, "inner path beat carries summary")
  `CWSP_ASSERT(a_empty_beat, res_valid && !edge_present |-> last && total_cost == 32'd0, "beat without edge is not a bare final")

endmodule

bind congestion_weighted_shortest_path_unit cwsp_checker u_cwsp_checker (.*);
